// ===== rtl/ccsc_pkg.sv =====
// Shared types and constants for the climate chamber switch controller.
package ccsc_pkg;

	localparam int unsigned InWidth   = 88;
	localparam int unsigned OutWidth  = 8;
	localparam int unsigned CfgWidth  = 64;
	localparam int unsigned AddrWidth = 6;

	localparam logic signed [11:0] MinTempReset     = 12'sd700;
	localparam logic signed [11:0] MaxTempReset     = 12'sd800;
	localparam logic [9:0]         MinHumidityReset = 10'd800;
	localparam logic [31:0]        AirIntervalReset = 32'd900000000;
	localparam logic [31:0]        AirDurationReset = 32'd120000000;
	localparam logic [39:0]        LightOnReset     = 40'd43200000000;
	localparam logic [39:0]        LightPeriodReset = 40'd86400000000;
	localparam logic [6:0]         FailLimitReset   = 7'd20;

	localparam logic signed [15:0] FahrScale  = 16'sd9;
	localparam logic signed [15:0] FahrOffset = 16'sd1600;
	localparam logic signed [15:0] ThreshScale = 16'sd5;

	typedef enum logic [2:0] {
		REG_MIN_TEMP     = 3'd0,
		REG_MAX_TEMP     = 3'd1,
		REG_MIN_HUMIDITY = 3'd2,
		REG_AIR_INTERVAL = 3'd3,
		REG_AIR_DURATION = 3'd4,
		REG_LIGHT_ON     = 3'd5,
		REG_LIGHT_PERIOD = 3'd6,
		REG_FAIL_LIMIT   = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic humidifier_on;
		logic pump_on;
		logic light_on;
		logic heater_on;
		logic fans_on;
	} switch_t;

endpackage

// ===== rtl/climate_chamber_switch_controller.sv =====
// Climate chamber switch controller: sensor tick in, switch states out.
//
// Each request on the input stream is one control tick carrying the sensor
// status, temperature, humidity, water-low flag and the microsecond time.
// Each tick produces exactly one request on the output stream with the five
// switch states, the status LED and the sensor fault flag.
// A tick is latched into an input stage, evaluated against the chamber
// state and written to the output register. One tick can be accepted
// every cycle while the receiver does not stall; the rate is set by the
// state update, a 64-bit subtract and compare per timer.
// When the receiver stalls, the output register holds its result and the
// input stage fills; the input ready drops only when both are occupied.
// Reset clears the timers, the fail count and all switches, turns the
// status LED on and loads the default thresholds and timings.
// Thresholds and timings are written over the APB port at byte address
// eight times the register number and may be read back there.
module climate_chamber_switch_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sensor_ok, temp_tenths_c[10:0], humidity_tenths[9:0], water_low, now_us[63:0]
	input  logic [ccsc_pkg::InWidth-1:0]         s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// fans_on, heater_on, light_on, pump_on, humidifier_on, status_led, sensor_fault
	output logic [ccsc_pkg::OutWidth-1:0]        m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ccsc_pkg::AddrWidth-1:0]       paddr,
	input  logic [ccsc_pkg::CfgWidth-1:0]        pwdata,
	output logic [ccsc_pkg::CfgWidth-1:0]        prdata,
	output logic                                 pready
);

	logic signed [11:0] min_temp_q;
	logic signed [11:0] max_temp_q;
	logic [9:0]         min_humidity_q;
	logic [31:0]        air_interval_q;
	logic [31:0]        air_duration_q;
	logic [39:0]        light_on_q;
	logic [39:0]        light_period_q;
	logic [6:0]         fail_limit_q;

	logic               valid_s1;
	logic               sensor_ok_s1;
	logic signed [10:0] temp_s1;
	logic [9:0]         humidity_s1;
	logic               water_low_s1;
	logic [63:0]        now_s1;

	logic [63:0]        air_start_q;
	logic [63:0]        light_start_q;
	logic [6:0]         fail_count_q;
	ccsc_pkg::switch_t  switches_q;
	logic               led_q;

	logic               out_valid_q;
	ccsc_pkg::switch_t  out_switches_q;
	logic               out_led_q;
	logic               out_fault_q;

	ccsc_pkg::reg_index_t reg_index;
	logic               cfg_write;
	logic               advance;

	logic signed [15:0] temp_f;
	logic signed [15:0] min_scaled;
	logic signed [15:0] max_scaled;
	logic               too_hot;
	logic [63:0]        air_elapsed;
	logic [63:0]        light_elapsed;
	logic               air_restart;
	logic               light_window;
	logic               light_restart;
	logic [6:0]         limit;
	logic [6:0]         count_next;
	logic               at_limit;
	ccsc_pkg::switch_t  switches_next;
	logic               led_next;

	assign pready    = 1'b1;
	assign reg_index = ccsc_pkg::reg_index_t'(paddr[5:3]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_index)
			ccsc_pkg::REG_MIN_TEMP:     prdata = {52'd0, min_temp_q};
			ccsc_pkg::REG_MAX_TEMP:     prdata = {52'd0, max_temp_q};
			ccsc_pkg::REG_MIN_HUMIDITY: prdata = {54'd0, min_humidity_q};
			ccsc_pkg::REG_AIR_INTERVAL: prdata = {32'd0, air_interval_q};
			ccsc_pkg::REG_AIR_DURATION: prdata = {32'd0, air_duration_q};
			ccsc_pkg::REG_LIGHT_ON:     prdata = {24'd0, light_on_q};
			ccsc_pkg::REG_LIGHT_PERIOD: prdata = {24'd0, light_period_q};
			ccsc_pkg::REG_FAIL_LIMIT:   prdata = {57'd0, fail_limit_q};
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q     <= ccsc_pkg::MinTempReset;
			max_temp_q     <= ccsc_pkg::MaxTempReset;
			min_humidity_q <= ccsc_pkg::MinHumidityReset;
			air_interval_q <= ccsc_pkg::AirIntervalReset;
			air_duration_q <= ccsc_pkg::AirDurationReset;
			light_on_q     <= ccsc_pkg::LightOnReset;
			light_period_q <= ccsc_pkg::LightPeriodReset;
			fail_limit_q   <= ccsc_pkg::FailLimitReset;
		end else if (cfg_write) begin
			unique case (reg_index)
				ccsc_pkg::REG_MIN_TEMP:     min_temp_q     <= pwdata[11:0];
				ccsc_pkg::REG_MAX_TEMP:     max_temp_q     <= pwdata[11:0];
				ccsc_pkg::REG_MIN_HUMIDITY: min_humidity_q <= pwdata[9:0];
				ccsc_pkg::REG_AIR_INTERVAL: air_interval_q <= pwdata[31:0];
				ccsc_pkg::REG_AIR_DURATION: air_duration_q <= pwdata[31:0];
				ccsc_pkg::REG_LIGHT_ON:     light_on_q     <= pwdata[39:0];
				ccsc_pkg::REG_LIGHT_PERIOD: light_period_q <= pwdata[39:0];
				ccsc_pkg::REG_FAIL_LIMIT:   fail_limit_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sensor_ok_s1 <= s_tdata[0];
			temp_s1      <= s_tdata[11:1];
			humidity_s1  <= s_tdata[21:12];
			water_low_s1 <= s_tdata[22];
			now_s1       <= s_tdata[86:23];
		end
	end

	assign temp_f     = $signed({{5{temp_s1[10]}}, temp_s1}) * ccsc_pkg::FahrScale
		+ ccsc_pkg::FahrOffset;
	assign min_scaled = $signed({{4{min_temp_q[11]}}, min_temp_q}) * ccsc_pkg::ThreshScale;
	assign max_scaled = $signed({{4{max_temp_q[11]}}, max_temp_q}) * ccsc_pkg::ThreshScale;
	assign too_hot    = temp_f > max_scaled;

	assign air_elapsed   = now_s1 - air_start_q;
	assign light_elapsed = now_s1 - light_start_q;
	assign air_restart   = air_elapsed >= {32'd0, air_interval_q};
	assign light_window  = light_elapsed < {24'd0, light_on_q};
	assign light_restart = !light_window && (light_elapsed >= {24'd0, light_period_q});

	assign limit      = (fail_limit_q == 7'd0) ? 7'd1 : fail_limit_q;
	assign count_next = sensor_ok_s1 ? 7'd0
		: ((fail_count_q < limit) ? fail_count_q + 7'd1 : limit);
	assign at_limit   = count_next >= limit;

	always_comb begin
		switches_next = switches_q;
		led_next      = led_q;
		if (sensor_ok_s1) begin
			switches_next.fans_on       = too_hot || air_restart
				|| (air_elapsed < {32'd0, air_duration_q});
			switches_next.heater_on     = temp_f < min_scaled;
			switches_next.light_on      = light_window;
			switches_next.pump_on       = water_low_s1;
			switches_next.humidifier_on = humidity_s1 < min_humidity_q;
		end else if (at_limit) begin
			switches_next = '0;
			led_next      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_start_q   <= '0;
			light_start_q <= '0;
			fail_count_q  <= '0;
			switches_q    <= '0;
			led_q         <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				if (sensor_ok_s1 && !too_hot && air_restart) begin
					air_start_q <= now_s1;
				end
				if (sensor_ok_s1 && light_restart) begin
					light_start_q <= now_s1;
				end
				fail_count_q <= count_next;
				switches_q   <= switches_next;
				led_q        <= led_next;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_switches_q <= switches_next;
			out_led_q      <= led_next;
			out_fault_q    <= at_limit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_fault_q, out_led_q, out_switches_q.humidifier_on,
		out_switches_q.pump_on, out_switches_q.light_on, out_switches_q.heater_on,
		out_switches_q.fans_on};

endmodule
